FILE: design/tpbd_pkg.sv
`timescale 1ns / 1ps
// Package for the tape pulse byte deframer: widths, sync constants, the
// one-hot phase codes and the state and result structs. No dependencies.
package tpbd_pkg;

    localparam int SAMPLE_W = 8;
    localparam int BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] BIT_PATTERN = 8'h68;
    localparam logic [BYTE_W-1:0] LEAD_BYTE   = 8'h16;
    localparam logic [BYTE_W-1:0] START_BYTE  = 8'h24;

    // Runs shorter than this many samples decode as a 1.
    localparam logic [1:0] SHORT_LIMIT = 2'd3;
    // Lead bytes needed before the start byte is looked for.
    localparam logic [1:0] LEAD_NEEDED = 2'd3;
    // Data bits in one frame.
    localparam logic [3:0] DATA_BITS   = 4'd8;
    // Index of the start byte within the regenerated header.
    localparam logic [1:0] HDR_LAST_IDX = 2'd3;

    typedef enum logic [3:0] {
        FP_START  = 4'b0001,
        FP_SKIP   = 4'b0010,
        FP_DATA   = 4'b0100,
        FP_PARITY = 4'b1000
    } t_frame_phase;

    typedef enum logic [2:0] {
        SS_BIT_HUNT  = 3'b001,
        SS_BYTE_HUNT = 3'b010,
        SS_SYNCED    = 3'b100
    } t_sync_stage;

    typedef struct packed {
        logic              run_phase;
        logic [1:0]        run_length;
        t_frame_phase      frame_phase;
        logic [3:0]        bit_counter;
        logic [BYTE_W-1:0] data_shift;
        logic              ones_parity;
        logic [BYTE_W-1:0] hunt_shift;
        t_sync_stage       sync_stage;
        logic [1:0]        lead_count;
    } t_tpbd_state;

    typedef struct packed {
        logic              has_byte;
        logic              has_hdr;
        logic [BYTE_W-1:0] data_byte;
        logic              parity_error;
    } t_tpbd_res;

endpackage

FILE: design/tpbd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample words and decoded result words.
// Depends on tpbd_pkg for the payload widths.
interface tpbd_in_if;
    logic                          valid;
    logic                          ready;
    logic [tpbd_pkg::SAMPLE_W-1:0] sample_bits;

    modport source (output valid, output sample_bits, input ready);
    modport sink   (input valid, input sample_bits, output ready);
endinterface

interface tpbd_out_if;
    logic                        valid;
    logic                        ready;
    logic [tpbd_pkg::BYTE_W-1:0] data_byte;
    logic                        parity_error;
    logic                        last;

    modport source (output valid, output data_byte, output parity_error, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input parity_error, input last,
                    output ready);
endinterface

FILE: design/tpbd_step.sv
`timescale 1ns / 1ps
// Combinational next-state logic for one sample word: pulse-width bit
// decoding, bit and byte hunt, byte framing. Depends on tpbd_pkg.
module tpbd_step (
    input  logic [tpbd_pkg::SAMPLE_W-1:0] i_samples,
    input  tpbd_pkg::t_tpbd_state         i_state,
    output tpbd_pkg::t_tpbd_state         o_state,
    output tpbd_pkg::t_tpbd_res           o_res
);
    import tpbd_pkg::*;

    always_comb begin : p_step
        t_tpbd_state       s;
        t_tpbd_res         res;
        logic              smp;
        logic              b;
        logic [BYTE_W-1:0] byte_val;
        logic              perr;

        s        = i_state;
        res      = '0;
        b        = 1'b0;
        byte_val = '0;
        perr     = 1'b0;

        // Samples are taken most significant first.
        for (int i = SAMPLE_W - 1; i >= 0; i--) begin
            smp = i_samples[i];
            if (s.run_length < SHORT_LIMIT) begin
                s.run_length = s.run_length + 2'd1;
            end
            if (!s.run_phase) begin
                if (!smp) begin
                    s.run_phase = 1'b1;
                end
            end else if (smp) begin
                // A full low-then-high pulse ends here: one decoded bit.
                b            = (s.run_length < SHORT_LIMIT);
                s.run_phase  = 1'b0;
                s.run_length = 2'd0;
                if (s.sync_stage == SS_BIT_HUNT) begin
                    s.hunt_shift = {s.hunt_shift[BYTE_W-2:0], b};
                    if (s.hunt_shift == BIT_PATTERN) begin
                        s.sync_stage  = SS_BYTE_HUNT;
                        s.lead_count  = 2'd0;
                        s.frame_phase = FP_START;
                        s.bit_counter = 4'd0;
                        s.data_shift  = '0;
                        s.ones_parity = 1'b0;
                    end
                end else begin
                    case (s.frame_phase)
                        FP_START: begin
                            s.frame_phase = FP_SKIP;
                        end
                        FP_SKIP: begin
                            if (!b) begin
                                s.frame_phase = FP_DATA;
                                s.bit_counter = 4'd0;
                                s.data_shift  = '0;
                                s.ones_parity = 1'b0;
                            end
                        end
                        FP_DATA: begin
                            s.data_shift  = {b, s.data_shift[BYTE_W-1:1]};
                            s.ones_parity = s.ones_parity ^ b;
                            s.bit_counter = s.bit_counter + 4'd1;
                            if (s.bit_counter >= DATA_BITS) begin
                                s.frame_phase = FP_PARITY;
                            end
                        end
                        default: begin
                            // Parity bit closes the frame.
                            s.frame_phase = FP_START;
                            s.bit_counter = 4'd0;
                            byte_val      = s.data_shift;
                            perr          = (s.ones_parity == b);
                            if (s.sync_stage == SS_BYTE_HUNT) begin
                                if (s.lead_count < LEAD_NEEDED) begin
                                    s.lead_count = (byte_val == LEAD_BYTE) ?
                                                   s.lead_count + 2'd1 : 2'd0;
                                end else if (byte_val == START_BYTE) begin
                                    s.sync_stage = SS_SYNCED;
                                    res.has_hdr  = 1'b1;
                                end else if (byte_val != LEAD_BYTE) begin
                                    s.lead_count = 2'd0;
                                end
                            end else begin
                                res.has_byte     = 1'b1;
                                res.data_byte    = byte_val;
                                res.parity_error = perr;
                            end
                        end
                    endcase
                end
            end
        end

        o_state = s;
        o_res   = res;
    end

endmodule

FILE: design/tape_pulse_byte_deframer_core.sv
`timescale 1ns / 1ps
// Top level of the tape pulse byte deframer: input register, state register,
// result register and output sequencer. Depends on tpbd_pkg, tpbd_if, tpbd_step.
//
// Usage:
//   i_in carries sample words of eight one-bit tape samples, oldest sample in
//   the most significant bit. o_out carries decoded words: a data byte, its
//   parity error flag and a last flag that marks the final result caused by
//   one sample word. Both channels move a word when valid and ready are high
//   at the same rising edge.
//   A sample word is held in an input register, then decoded combinationally
//   into the state register and the result register, from which its first
//   result is offered. One sample word is taken every cycle as long as the
//   result register is free or hands out its last result in that cycle. A
//   word produces no result, one data byte, or the four byte sync header; the
//   header holds the result register until all four bytes are taken, during
//   which at most one further word waits in the input register.
//   If the receiver stalls, the result register holds, the input register
//   fills, and i_in.ready drops until the pending result is taken.
//   Synchronous reset (i_rst_n low) returns the decoder to the bit hunt,
//   empties both registers and drops all pending results.
module tape_pulse_byte_deframer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tpbd_in_if.sink           i_in,
    tpbd_out_if.source        o_out
);
    import tpbd_pkg::*;

    localparam t_tpbd_state STATE_RESET = '{
        run_phase:   1'b0,
        run_length:  2'd0,
        frame_phase: FP_START,
        bit_counter: 4'd0,
        data_shift:  '0,
        ones_parity: 1'b0,
        hunt_shift:  '0,
        sync_stage:  SS_BIT_HUNT,
        lead_count:  2'd0
    };

    // Input register.
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_in_bits;

    // Decoder state.
    t_tpbd_state r_state;
    t_tpbd_state n_state;
    t_tpbd_res   n_res;

    // Result register: either one data byte or the four byte header, walked by r_b_idx.
    logic              r_b_valid;
    logic              r_b_hdr;
    logic [BYTE_W-1:0] r_b_byte;
    logic              r_b_perr;
    logic [1:0]        r_b_idx;

    logic out_fire;
    logic drain_done;
    logic proc;

    tpbd_step u_step (
        .i_samples (r_in_bits),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_res     (n_res)
    );

    // Output side. The header replays lead, lead, lead, start.
    assign o_out.valid        = r_b_valid;
    assign o_out.data_byte    = !r_b_hdr ? r_b_byte :
                                (r_b_idx == HDR_LAST_IDX) ? START_BYTE : LEAD_BYTE;
    assign o_out.parity_error = !r_b_hdr && r_b_perr;
    assign o_out.last         = !r_b_hdr || (r_b_idx == HDR_LAST_IDX);

    assign out_fire   = o_out.valid && o_out.ready;
    assign drain_done = out_fire && o_out.last;

    // The held word is decoded once the result register is free or is being
    // emptied in this very cycle.
    assign proc       = r_in_valid && (!r_b_valid || drain_done);
    assign i_in.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_bits <= i_in.sample_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= 2'd0;
        end else if (proc && (n_res.has_byte || n_res.has_hdr)) begin
            r_b_valid <= 1'b1;
            r_b_idx   <= 2'd0;
        end else if (drain_done) begin
            r_b_valid <= 1'b0;
        end else if (out_fire) begin
            r_b_idx   <= r_b_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && (n_res.has_byte || n_res.has_hdr)) begin
            r_b_hdr  <= n_res.has_hdr;
            r_b_byte <= n_res.data_byte;
            r_b_perr <= n_res.parity_error;
        end
    end

endmodule
